// ===== design/mdq_pkg.sv =====
package mdq_pkg;

  // operation codes carried in the input word
  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_MERGE     = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NOFREE = 2'd2,
    ST_SELF   = 2'd3
  } status_e;

  // payload widths
  localparam int unsigned OpW        = 3;
  localparam int unsigned ListFieldW = 3;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InTdataW   = 48;
  localparam int unsigned OutTdataW  = 40;

endpackage

// ===== design/mdq_ram.sv =====
module mdq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic             byp_q;
  logic [WIDTH-1:0] bypd_q;

  // one write and one registered read, all moving together on enable
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[waddr_i] <= wdata_i;
      end
      rd_q   <= mem_q[raddr_i];
      byp_q  <= we_i && (waddr_i == raddr_i);
      bypd_q <= wdata_i;
    end
  end

  // a read that collides with the write returns the new word
  assign rdata_o = byp_q ? bypd_q : rd_q;

endmodule

// ===== design/multi_deque_linked_node_pool.sv =====
// Multi-deque linked node pool: LIST_COUNT double-ended lists share NODE_COUNT
// linked nodes. Each input word carries an opcode (push head/tail, pop
// head/tail, merge list_b onto list_a, clear list_a) and gives one result word
// with a status code and the popped value (zero unless a pop succeeds).
// Input word (s_axis): opcode, list_a, list_b, value. Output word (m_axis):
// status, popped_value. A word is taken when tvalid and tready are both high.
// Stages: the first stage, the second stage and the result register, in order.
// Throughput: one word per cycle unless stalled. List pointers are read when
// the word is taken, node links in the first stage, and all updates are
// written in the second stage; writes of the older word reach the younger one.
// Stall: when the result register is full and m_axis_tready_i is low, the
// whole pipeline holds and s_axis_tready_o drops; nothing is lost.
// Reset: all lists are empty, the free chain is empty and no node of the pool
// has been handed out; node and pointer memories need no clearing pass.
module multi_deque_linked_node_pool #(
  parameter int unsigned LIST_COUNT = 8,
  parameter int unsigned NODE_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [2:0] opcode, [5:3] list_a, [8:6] list_b, [40:9] value, [47:41] zero
  input  logic [mdq_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [33:2] popped_value, [39:34] zero
  output logic [mdq_pkg::OutTdataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned FW = $clog2(NODE_COUNT + 1);
  localparam int unsigned VW = mdq_pkg::ValueW;

  // list index wraps modulo the list count
  function automatic logic [LW-1:0] list_wrap(input logic [mdq_pkg::ListFieldW-1:0] x);
    logic [4:0] r;
    r = {2'b00, x};
    for (int i = 0; i < 8; i++) begin
      if (r >= 5'(LIST_COUNT)) begin
        r = r - 5'(LIST_COUNT);
      end
    end
    return r[LW-1:0];
  endfunction

  logic adv;

  // input word fields
  logic [mdq_pkg::OpW-1:0] in_op;
  logic [LW-1:0]           in_a;
  logic [LW-1:0]           in_b;
  logic [LW-1:0]           in_faddr;

  // first stage: list pointers come back from the list memories
  logic                    s1_valid_q;
  logic [mdq_pkg::OpW-1:0] s1_op_q;
  logic [LW-1:0]           s1_a_q;
  logic [LW-1:0]           s1_b_q;
  logic [VW-1:0]           s1_val_q;
  logic [LW-1:0]           s1_faddr;
  logic [NW-1:0]           first_rd;
  logic [NW-1:0]           last_a_rd;
  logic [NW-1:0]           last_b_rd;
  logic [NW-1:0]           first_eff;
  logic [NW-1:0]           last_a_eff;
  logic [NW-1:0]           last_b_eff;
  logic [NW-1:0]           data_raddr;
  logic [NW-1:0]           fwd_raddr;

  // second stage: node words come back, updates are computed and written
  logic                    s2_valid_q;
  logic [mdq_pkg::OpW-1:0] s2_op_q;
  logic [LW-1:0]           s2_a_q;
  logic [LW-1:0]           s2_b_q;
  logic [VW-1:0]           s2_val_q;
  logic [NW-1:0]           s2_first_q;
  logic [NW-1:0]           s2_last_a_q;
  logic [NW-1:0]           s2_last_b_q;
  logic [VW-1:0]           nd_data;
  logic [NW-1:0]           nd_fwd;
  logic [NW-1:0]           nd_bwd;

  // pool and list state
  logic [LIST_COUNT-1:0]   occ_q, occ_d;
  logic [NW-1:0]           free_top_q, free_top_d;
  logic                    free_valid_q, free_valid_d;
  logic [FW-1:0]           fresh_q, fresh_d;

  // node taking
  logic                    take_ok;
  logic [NW-1:0]           take_n;
  logic [NW-1:0]           tk_top;
  logic                    tk_valid;
  logic [FW-1:0]           tk_fresh;

  // write ports
  logic                    f_we, l_we, d_we, fw_we, bw_we;
  logic [LW-1:0]           f_wa, l_wa;
  logic [NW-1:0]           f_wd, l_wd;
  logic [NW-1:0]           d_wa, fw_wa, fw_wd, bw_wa, bw_wd;
  logic [NW-1:0]           pop_n;

  // result
  mdq_pkg::status_e        res_status;
  logic [VW-1:0]           res_popped;
  logic                    out_valid_q;
  mdq_pkg::status_e        out_status_q;
  logic [VW-1:0]           out_popped_q;

  // the whole pipeline moves whenever the result register can take a word
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  assign in_op    = s_axis_tdata_i[2:0];
  assign in_a     = list_wrap(s_axis_tdata_i[5:3]);
  assign in_b     = list_wrap(s_axis_tdata_i[8:6]);
  assign in_faddr = (in_op == mdq_pkg::OP_MERGE) ? in_b : in_a;

  // list pointer memories, the last pointer kept twice for two read ports
  mdq_ram #(.DEPTH(LIST_COUNT), .WIDTH(NW)) u_first (
    .clk_i, .en_i(adv), .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd),
    .raddr_i(in_faddr), .rdata_o(first_rd)
  );
  mdq_ram #(.DEPTH(LIST_COUNT), .WIDTH(NW)) u_last_a (
    .clk_i, .en_i(adv), .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
    .raddr_i(in_a), .rdata_o(last_a_rd)
  );
  mdq_ram #(.DEPTH(LIST_COUNT), .WIDTH(NW)) u_last_b (
    .clk_i, .en_i(adv), .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
    .raddr_i(in_b), .rdata_o(last_b_rd)
  );

  // forward list writes of the older word into the first stage
  assign s1_faddr   = (s1_op_q == mdq_pkg::OP_MERGE) ? s1_b_q : s1_a_q;
  assign first_eff  = (f_we && f_wa == s1_faddr) ? f_wd : first_rd;
  assign last_a_eff = (l_we && l_wa == s1_a_q) ? l_wd : last_a_rd;
  assign last_b_eff = (l_we && l_wa == s1_b_q) ? l_wd : last_b_rd;

  // node read addresses: popped node, or the free chain top for a push
  assign data_raddr = (s1_op_q == mdq_pkg::OP_POP_HEAD) ? first_eff : last_a_eff;
  assign fwd_raddr  = (s1_op_q == mdq_pkg::OP_POP_HEAD) ? first_eff : free_top_d;

  mdq_ram #(.DEPTH(NODE_COUNT), .WIDTH(VW)) u_data (
    .clk_i, .en_i(adv), .we_i(d_we), .waddr_i(d_wa), .wdata_i(s2_val_q),
    .raddr_i(data_raddr), .rdata_o(nd_data)
  );
  mdq_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_fwd (
    .clk_i, .en_i(adv), .we_i(fw_we), .waddr_i(fw_wa), .wdata_i(fw_wd),
    .raddr_i(fwd_raddr), .rdata_o(nd_fwd)
  );
  mdq_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_bwd (
    .clk_i, .en_i(adv), .we_i(bw_we), .waddr_i(bw_wa), .wdata_i(bw_wd),
    .raddr_i(last_a_eff), .rdata_o(nd_bwd)
  );

  // take a node from the free chain, else from the unused part of the pool
  always_comb begin
    take_ok  = 1'b1;
    take_n   = free_top_q;
    tk_top   = free_top_q;
    tk_valid = free_valid_q;
    tk_fresh = fresh_q;
    if (free_valid_q) begin
      if (nd_fwd == free_top_q) begin
        tk_valid = 1'b0;
      end else begin
        tk_top = nd_fwd;
      end
    end else if (fresh_q < FW'(NODE_COUNT)) begin
      take_n   = fresh_q[NW-1:0];
      tk_fresh = fresh_q + FW'(1);
    end else begin
      take_ok = 1'b0;
    end
  end

  assign pop_n = (s2_op_q == mdq_pkg::OP_POP_HEAD) ? s2_first_q : s2_last_a_q;

  // list update for the word in the second stage
  always_comb begin
    res_status   = mdq_pkg::ST_OK;
    res_popped   = '0;
    f_we         = 1'b0;
    f_wa         = s2_a_q;
    f_wd         = take_n;
    l_we         = 1'b0;
    l_wa         = s2_a_q;
    l_wd         = take_n;
    d_we         = 1'b0;
    d_wa         = take_n;
    fw_we        = 1'b0;
    fw_wa        = take_n;
    fw_wd        = s2_first_q;
    bw_we        = 1'b0;
    bw_wa        = s2_first_q;
    bw_wd        = take_n;
    occ_d        = occ_q;
    free_top_d   = free_top_q;
    free_valid_d = free_valid_q;
    fresh_d      = fresh_q;
    if (s2_valid_q) begin
      case (s2_op_q) inside
        mdq_pkg::OP_PUSH_HEAD, mdq_pkg::OP_PUSH_TAIL: begin
          if (!take_ok) begin
            res_status = mdq_pkg::ST_NOFREE;
          end else begin
            free_top_d   = tk_top;
            free_valid_d = tk_valid;
            fresh_d      = tk_fresh;
            d_we         = 1'b1;
            if (!occ_q[s2_a_q]) begin
              f_we            = 1'b1;
              l_we            = 1'b1;
              occ_d[s2_a_q]   = 1'b1;
            end else if (s2_op_q == mdq_pkg::OP_PUSH_HEAD) begin
              fw_we = 1'b1;
              bw_we = 1'b1;
              f_we  = 1'b1;
            end else begin
              fw_we = 1'b1;
              fw_wa = s2_last_a_q;
              fw_wd = take_n;
              bw_we = 1'b1;
              bw_wa = take_n;
              bw_wd = s2_last_a_q;
              l_we  = 1'b1;
            end
          end
        end
        mdq_pkg::OP_POP_HEAD, mdq_pkg::OP_POP_TAIL: begin
          if (!occ_q[s2_a_q]) begin
            res_status = mdq_pkg::ST_EMPTY;
          end else begin
            res_popped = nd_data;
            if (s2_first_q == s2_last_a_q) begin
              occ_d[s2_a_q] = 1'b0;
            end else if (s2_op_q == mdq_pkg::OP_POP_HEAD) begin
              f_we = 1'b1;
              f_wd = nd_fwd;
            end else begin
              l_we = 1'b1;
              l_wd = nd_bwd;
            end
            // the single popped node goes on top of the free chain
            fw_we        = 1'b1;
            fw_wa        = pop_n;
            fw_wd        = free_valid_q ? free_top_q : pop_n;
            free_top_d   = pop_n;
            free_valid_d = 1'b1;
          end
        end
        mdq_pkg::OP_MERGE: begin
          if (s2_a_q == s2_b_q) begin
            res_status = mdq_pkg::ST_SELF;
          end else if (!occ_q[s2_b_q]) begin
            res_status = mdq_pkg::ST_EMPTY;
          end else begin
            if (!occ_q[s2_a_q]) begin
              f_we          = 1'b1;
              f_wd          = s2_first_q;
              occ_d[s2_a_q] = 1'b1;
            end else begin
              fw_we = 1'b1;
              fw_wa = s2_last_a_q;
              fw_wd = s2_first_q;
              bw_we = 1'b1;
              bw_wa = s2_first_q;
              bw_wd = s2_last_a_q;
            end
            l_we          = 1'b1;
            l_wd          = s2_last_b_q;
            occ_d[s2_b_q] = 1'b0;
          end
        end
        mdq_pkg::OP_CLEAR: begin
          if (occ_q[s2_a_q]) begin
            // splice the whole chain onto the free chain
            fw_we         = 1'b1;
            fw_wa         = s2_last_a_q;
            fw_wd         = free_valid_q ? free_top_q : s2_last_a_q;
            free_top_d    = s2_first_q;
            free_valid_d  = 1'b1;
            occ_d[s2_a_q] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline and pool control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      occ_q        <= '0;
      free_top_q   <= '0;
      free_valid_q <= 1'b0;
      fresh_q      <= '0;
    end else if (adv) begin
      s1_valid_q   <= s_axis_tvalid_i;
      s2_valid_q   <= s1_valid_q;
      out_valid_q  <= s2_valid_q;
      occ_q        <= occ_d;
      free_top_q   <= free_top_d;
      free_valid_q <= free_valid_d;
      fresh_q      <= fresh_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q      <= in_op;
      s1_a_q       <= in_a;
      s1_b_q       <= in_b;
      s1_val_q     <= s_axis_tdata_i[40:9];
      s2_op_q      <= s1_op_q;
      s2_a_q       <= s1_a_q;
      s2_b_q       <= s1_b_q;
      s2_val_q     <= s1_val_q;
      s2_first_q   <= first_eff;
      s2_last_a_q  <= last_a_eff;
      s2_last_b_q  <= last_b_eff;
      out_status_q <= res_status;
      out_popped_q <= res_popped;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_popped_q, out_status_q};

`ifndef SYNTHESIS
  // the pool counter never runs past the node count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= FW'(NODE_COUNT))
    else $error("fresh node count beyond pool size");

  // a nonzero popped value only comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status_q != mdq_pkg::ST_OK) |-> out_popped_q == '0)
    else $error("popped value on a failed operation");

  // the free chain only runs dry by a push taking its last node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(free_valid_q) |-> $past(s2_valid_q && (s2_op_q == mdq_pkg::OP_PUSH_HEAD ||
                                                 s2_op_q == mdq_pkg::OP_PUSH_TAIL)))
    else $error("free chain emptied by a non-push operation");

  // list pointers are only written by a word that succeeds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_we || l_we) |-> res_status == mdq_pkg::ST_OK)
    else $error("list pointer write on a failed operation");

  // a word in the first stage reaches the second stage on the next move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> s2_valid_q)
    else $error("word lost between pipeline stages");
`endif

endmodule
